FILE: rtl/rsh_pkg.sv
package rsh_pkg;

  // Line store depth, frame size limits and field widths
  localparam int MaxWidth  = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int WidthW    = 12;
  localparam int MaxHeight = 4096;
  localparam int HeightW   = 13;
  localparam int RowW      = 13;
  localparam int GainW     = 13;
  localparam int ChanW     = 8;
  localparam int PixW      = 3 * ChanW;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 13;

  // Output queue: one result entry is {last_pixel, blue, green, red}
  localparam int ResW      = PixW + 1;
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic [PixW-1:0]   pix_t;
  typedef logic [ChanW-1:0]  chan_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgGain   = 2'd2
  } cfg_idx_e;

endpackage

FILE: rtl/rsh_in_if.sv
interface rsh_in_if;
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [rsh_pkg::ChanW-1:0] red;
  logic [rsh_pkg::ChanW-1:0] green;
  logic [rsh_pkg::ChanW-1:0] blue;

  modport source (output valid, output mode, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input mode, input red, input green, input blue,
                  output ready);
endinterface

FILE: rtl/rsh_out_if.sv
interface rsh_out_if;
  logic                   valid;
  logic                   ready;
  logic [rsh_pkg::ChanW-1:0] out_red;
  logic [rsh_pkg::ChanW-1:0] out_green;
  logic [rsh_pkg::ChanW-1:0] out_blue;
  logic                   last_pixel;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output last_pixel, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input last_pixel, output ready);
endinterface

FILE: rtl/rgb_sharpen_3x3.sv
// rgb_sharpen_3x3: streaming 3x3 Laplacian sharpen of an RGB frame sent in raster
// order. Each channel gives clamp((256*c + (9*c - neighbors)*gain) / 256, 0, 255),
// where gain is signed Q8 and pixels outside the frame count as zero. The result
// for a pixel leaves after the transaction that carries the pixel one row and one
// column later, so after the last pixel send image_width+1 drain transactions
// (mode 1); last_pixel marks the final result, after which a new frame starts.
// Throughput is one pixel per clock unless input stalls: both line stores share
// one memory of MaxWidth x 48 bits with read and write ports, read, then written
// back, once per pixel; a back-to-back access to the same column (one-pixel-wide
// frames) is forwarded. Results pass registers a, u, s, p and r into an 8-entry
// output queue that lets input continue while results wait; input stalls only
// when queue plus pipeline hold 8 items. Write configuration only while idle.
module rgb_sharpen_3x3 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rsh_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [rsh_pkg::CfgDataW-1:0]       cfg_wdata_i,
  rsh_in_if.sink                             in_i,
  rsh_out_if.source                          out_o
);

  localparam int ColW    = rsh_pkg::ColW;
  localparam int WidthW  = rsh_pkg::WidthW;
  localparam int HeightW = rsh_pkg::HeightW;
  localparam int RowW    = rsh_pkg::RowW;
  localparam int PixW    = rsh_pkg::PixW;
  localparam int ChanW   = rsh_pkg::ChanW;
  localparam int LineW   = 2 * PixW;

  // ---------------- configuration registers ----------------
  logic [WidthW-1:0]                 width_q;
  logic [HeightW-1:0]                height_q;
  logic signed [rsh_pkg::GainW-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(rsh_pkg::MaxWidth);
      height_q <= HeightW'(1);
      gain_q   <= '0;
    end else if (cfg_we_i) begin
      case (rsh_pkg::cfg_idx_e'(cfg_idx_i))
        rsh_pkg::CfgWidth:  width_q  <= cfg_wdata_i[WidthW-1:0];
        rsh_pkg::CfgHeight: height_q <= cfg_wdata_i[HeightW-1:0];
        rsh_pkg::CfgGain:   gain_q   <= $signed(cfg_wdata_i[rsh_pkg::GainW-1:0]);
        default: ;
      endcase
    end
  end

  // out-of-range sizes fold into the legal range
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  always_comb begin
    if (width_q == '0)                              w_eff = WidthW'(1);
    else if (width_q > WidthW'(rsh_pkg::MaxWidth))  w_eff = WidthW'(rsh_pkg::MaxWidth);
    else                                            w_eff = width_q;
    if (height_q == '0)                               h_eff = HeightW'(1);
    else if (height_q > HeightW'(rsh_pkg::MaxHeight)) h_eff = HeightW'(rsh_pkg::MaxHeight);
    else                                              h_eff = height_q;
  end

  // ---------------- flow control ----------------
  logic                           in_fire;
  logic                           a_valid_q, u_valid_q, s_valid_q, p_valid_q, r_valid_q;
  logic [rsh_pkg::FifoCntW-1:0]   fifo_count;
  logic [3:0]                     in_flight;
  logic                           fifo_valid;
  logic [rsh_pkg::ResW-1:0]       fifo_data;

  // every item in the pipe is counted as if it will produce a result
  assign in_flight = 4'(fifo_count) + 4'(a_valid_q) + 4'(u_valid_q) + 4'(s_valid_q)
                   + 4'(p_valid_q) + 4'(r_valid_q);
  assign in_i.ready = (in_flight < 4'(rsh_pkg::FifoDepth));
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------- position tracking (at accept) ----------------
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            col0;    // first column: emits last pixel of previous row
    logic            has;     // this transaction yields a result
    logic            left;    // result column 0: zero left neighbors
    logic            top;     // result row 0: zero upper neighbors
    logic            bot;     // result last row: zero lower neighbors
    logic            last;
  } pos_t;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  pos_t             pos;
  logic             row_ok;
  logic [RowW-1:0]  pr;
  logic [WidthW-1:0] pc;
  logic [WidthW-1:0] col_inc;

  always_comb begin
    pos.col  = col_q;
    pos.col0 = (col_q == '0);
    if (pos.col0) begin
      row_ok = (row_q >= RowW'(2));
      pr     = row_q - RowW'(2);
      pc     = w_eff - WidthW'(1);
    end else begin
      row_ok = (row_q != '0);
      pr     = row_q - RowW'(1);
      pc     = {1'b0, col_q} - WidthW'(1);
    end
    pos.has  = row_ok && (pr < h_eff) && (pc < w_eff);
    pos.left = (pc == '0);
    pos.top  = (pr == '0);
    pos.bot  = ({1'b0, pr} + 14'd1) >= {1'b0, h_eff};
    pos.last = pos.has && (pr == h_eff - HeightW'(1)) && (pc == w_eff - WidthW'(1));

    col_inc = {1'b0, col_q} + WidthW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (pos.last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w_eff) begin
      col_d = '0;
      if (row_q != {RowW{1'b1}}) row_d = row_q + RowW'(1);
    end else begin
      col_d = col_inc[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage A: accepted item, line store read ----------------
  pos_t             a_pos_q;
  rsh_pkg::pix_t    a_pix_q;
  logic [LineW-1:0] line_mem [rsh_pkg::MaxWidth];   // {upper, middle}
  logic [LineW-1:0] mem_rd_q;
  logic             fwd_q;
  logic [LineW-1:0] fwd_data_q;
  logic [LineW-1:0] line_rd;
  logic [LineW-1:0] line_wr;
  rsh_pkg::pix_t    top_pix, mid_pix;

  always_ff @(posedge clk_i) begin
    if (a_valid_q) line_mem[a_pos_q.col] <= line_wr;
    mem_rd_q <= line_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_pos_q    <= pos;
      a_pix_q    <= in_i.mode ? '0 : {in_i.blue, in_i.green, in_i.red};
      fwd_data_q <= line_wr;
    end
  end

  // same column written back while being read again
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      a_valid_q <= in_fire;
      if (in_fire) fwd_q <= a_valid_q && (a_pos_q.col == col_q);
    end
  end

  assign line_rd = fwd_q ? fwd_data_q : mem_rd_q;
  assign top_pix = line_rd[LineW-1:PixW];
  assign mid_pix = line_rd[PixW-1:0];
  assign line_wr = {mid_pix, a_pix_q};

  // ---------------- stage B: window shift and edge masking ----------------
  logic [2:0][2:0][PixW-1:0] win_q;   // [column][row], column 0 oldest, row 0 top
  logic [2:0][2:0][PixW-1:0] use_d, use_q;
  logic [2:0][PixW-1:0]      new_col;

  assign new_col = {a_pix_q, mid_pix, top_pix};

  always_comb begin
    use_d[0] = win_q[1];
    use_d[1] = win_q[2];
    use_d[2] = a_pos_q.col0 ? '0 : new_col;
    if (a_pos_q.left) use_d[0] = '0;
    for (int c = 0; c < 3; c++) begin
      if (a_pos_q.top) use_d[c][0] = '0;
      if (a_pos_q.bot) use_d[c][2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (a_valid_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= new_col;
    end
  end

  always_ff @(posedge clk_i) begin
    use_q <= use_d;
  end

  // ---------------- result valid / last tracking ----------------
  logic u_last_q, s_last_q, p_last_q, r_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else begin
      u_valid_q <= a_valid_q && a_pos_q.has;
      s_valid_q <= u_valid_q;
      p_valid_q <= s_valid_q;
      r_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u_last_q <= a_pos_q.last;
    s_last_q <= u_last_q;
    p_last_q <= s_last_q;
    r_last_q <= p_last_q;
  end

  // ---------------- channel arithmetic ----------------
  logic [8:0][ChanW-1:0] chan_win [3];
  logic [ChanW-1:0]      chan_res [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          chan_win[ch][c*3+r] = use_q[c][r][ch*ChanW +: ChanW];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    rsh_chan u_chan (
      .clk_i  (clk_i),
      .gain_i (gain_q),
      .win_i  (chan_win[ch]),
      .res_o  (chan_res[ch])
    );
  end

  // ---------------- output queue ----------------
  logic out_fire;
  assign out_fire = fifo_valid && out_o.ready;

  rsh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_valid_q),
    .data_i  ({r_last_q, chan_res[2], chan_res[1], chan_res[0]}),
    .pop_i   (out_fire),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .count_o (fifo_count)
  );

  assign out_o.valid      = fifo_valid;
  assign out_o.out_red    = fifo_data[ChanW-1:0];
  assign out_o.out_green  = fifo_data[2*ChanW-1:ChanW];
  assign out_o.out_blue   = fifo_data[3*ChanW-1:2*ChanW];
  assign out_o.last_pixel = fifo_data[PixW];

endmodule

FILE: rtl/rsh_chan.sv
// One color channel: Laplacian, gain multiply, scale and clamp, each step registered.
module rsh_chan (
  input  logic                               clk_i,
  input  logic signed [rsh_pkg::GainW-1:0]   gain_i,
  input  logic [8:0][rsh_pkg::ChanW-1:0]     win_i,   // [col*3+row], centre at 4
  output logic [rsh_pkg::ChanW-1:0]          res_o
);

  logic [10:0]        nb_sum;
  logic [11:0]        c9;
  logic signed [12:0] lap_d, lap_q;
  logic [7:0]         c1_q, c2_q;
  logic signed [25:0] prod_d, prod_q;
  logic signed [26:0] acc;
  logic [7:0]         res_d, res_q;

  always_comb begin
    nb_sum = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) nb_sum = nb_sum + 11'(win_i[i]);
    end
    c9    = {1'b0, win_i[4], 3'b000} + {4'b0000, win_i[4]};
    lap_d = 13'({1'b0, c9}) - 13'({2'b00, nb_sum});
  end

  assign prod_d = lap_q * gain_i;

  // negative sums clamp to zero, so truncation toward zero is a plain shift
  always_comb begin
    acc = $signed({11'd0, c2_q, 8'd0}) + $signed({prod_q[25], prod_q});
    if (acc[26]) begin
      res_d = '0;
    end else if (acc[25:16] != '0) begin
      res_d = 8'hFF;
    end else begin
      res_d = acc[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    lap_q  <= lap_d;
    c1_q   <= win_i[4];
    prod_q <= prod_d;
    c2_q   <= c1_q;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: rtl/rsh_fifo.sv
// Small result queue between the filter pipeline and the output channel.
module rsh_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [rsh_pkg::ResW-1:0]        data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output logic [rsh_pkg::ResW-1:0]        data_o,
  output logic [rsh_pkg::FifoCntW-1:0]    count_o
);

  logic [rsh_pkg::ResW-1:0]     mem_q [rsh_pkg::FifoDepth];
  logic [rsh_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rsh_pkg::FifoCntW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Stand-alone bench for rgb_sharpen_3x3. A behavioral copy of the filter, with its own
// line stores, window and counters, predicts every sharpened pixel at the moment the
// input transaction is accepted. A checker pops and compares each output transaction
// in order. Sender bursts and receiver stalls are random.
module testbench;
  import rsh_pkg::*;

  localparam int ClkHalf      = 6;           // 12 ns period
  localparam int RstCycles    = 11;
  localparam int SettleCycles = 16;          // pipeline plus margin
  localparam int RandItems    = 1150;
  localparam int MaxReports   = 10;

  // One expected output transaction
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } sharp_px_t;

  // Pixel content generators
  typedef enum int {
    PatRandom,
    PatFlat,
    PatChecker,
    PatSpeckle,
    PatRamp
  } pat_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rsh_in_if  in_bus ();
  rsh_out_if out_bus ();

  rgb_sharpen_3x3 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Filter predictor state
  // ------------------------------------------------------------------
  pix_t                  upper_row [MaxWidth];
  pix_t                  middle_row [MaxWidth];
  pix_t                  win [3][3];           // [column][row], column 0 oldest
  int                    col_cnt;
  int                    row_cnt;
  logic [WidthW-1:0]     reg_width;
  logic [HeightW-1:0]    reg_height;
  logic signed [GainW-1:0] reg_gain;

  sharp_px_t             sharpened_q [$];       // pixels still owed by the block
  bit                    frame_closed;          // set when last_pixel is predicted

  // Bookkeeping
  int unsigned fail_cnt     = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  int unsigned frames_sent  = 0;
  int          burst_left   = 0;
  bit          no_idle      = 1'b0;             // both sides run flat out when set

  function automatic void filter_reset();
    for (int i = 0; i < MaxWidth; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        win[c][r] = '0;
      end
    end
    col_cnt    = 0;
    row_cnt    = 0;
    reg_width  = WidthW'(MaxWidth);
    reg_height = HeightW'(1);
    reg_gain   = '0;
  endfunction

  function automatic void filter_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgWidth:  reg_width  = data[WidthW-1:0];
      CfgHeight: reg_height = data[HeightW-1:0];
      CfgGain:   reg_gain   = data[GainW-1:0];
      default: ;
    endcase
  endfunction

  // 9*centre - neighbors, scaled by Q8 gain, added to centre*256, truncated, clamped
  function automatic chan_t sharpen_chan(input pix_t nb [3][3], input int ch);
    int sum;
    int centre;
    int gi;
    int acc;
    int q;
    sum    = 0;
    gi     = reg_gain;
    centre = nb[1][1][ChanW*ch +: ChanW];
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (c != 1 || r != 1) sum += nb[c][r][ChanW*ch +: ChanW];
      end
    end
    acc = centre * 256 + (9 * centre - sum) * gi;
    q   = acc / 256;
    if (q < 0)   q = 0;
    if (q > 255) q = 255;
    return chan_t'(q);
  endfunction

  // Advance the predictor by one accepted input transaction
  function automatic void predict_sharpened(input logic md, input pix_t px_in);
    int        w;
    int        h;
    int        col;
    int        pr;
    int        pc;
    pix_t      px;
    pix_t      top;
    pix_t      mid;
    pix_t      prev [3][3];
    pix_t      nb [3][3];
    bit        last;
    sharp_px_t res;

    w = reg_width;
    h = reg_height;
    if (w == 0)        w = 1;
    if (w > MaxWidth)  w = MaxWidth;
    if (h == 0)        h = 1;
    if (h > MaxHeight) h = MaxHeight;
    col = col_cnt;
    if (col >= MaxWidth) col = MaxWidth - 1;

    px  = md ? '0 : px_in;   // drain reads as a zero pixel
    top = upper_row[col];
    mid = middle_row[col];
    upper_row[col]  = mid;
    middle_row[col] = px;

    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        prev[c][r] = win[c][r];
      end
    end
    for (int r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = px;

    // At column 0 the window still holds the end of the previous row
    if (col == 0) begin
      for (int r = 0; r < 3; r++) begin
        nb[0][r] = prev[1][r];
        nb[1][r] = prev[2][r];
        nb[2][r] = '0;
      end
      pr = row_cnt - 2;
      pc = w - 1;
    end else begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          nb[c][r] = win[c][r];
        end
      end
      pr = row_cnt - 1;
      pc = col - 1;
    end

    last = 1'b0;
    if (pr >= 0 && pr < h && pc < w) begin
      // zero the border outside the frame
      if (pc == 0) begin
        for (int r = 0; r < 3; r++) nb[0][r] = '0;
      end
      for (int c = 0; c < 3; c++) begin
        if (pr == 0)     nb[c][0] = '0;
        if (pr + 1 >= h) nb[c][2] = '0;
      end
      last      = (pr == h - 1) && (pc == w - 1);
      res.red   = sharpen_chan(nb, 0);
      res.green = sharpen_chan(nb, 1);
      res.blue  = sharpen_chan(nb, 2);
      res.last  = last;
      sharpened_q.push_back(res);
    end

    if (last) begin
      col_cnt      = 0;
      row_cnt      = 0;
      frame_closed = 1'b1;
    end else if (col + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < 8191) row_cnt++;
    end else begin
      col_cnt = col + 1;
    end
  endfunction

  // ------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // ------------------------------------------------------------------
  initial begin : result_check
    sharp_px_t   want;
    sharp_px_t   got;
    int unsigned hold;
    logic        rdy;
    hold = 0;
    rdy  = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got = {out_bus.out_red, out_bus.out_green, out_bus.out_blue, out_bus.last_pixel};
        if (sharpened_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("[%0t] unexpected result r=%0d g=%0d b=%0d last=%0d", $time,
                     got.red, got.green, got.blue, got.last);
        end else begin
          want = sharpened_q.pop_front();
          results_seen++;
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= MaxReports)
              $display("[%0t] pixel %0d: exp r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                       $time, results_seen, want.red, want.green, want.blue, want.last,
                       got.red, got.green, got.blue, got.last);
          end
        end
      end
      // ready: high and low runs of random length, stalls mostly short, some long
      if (no_idle) begin
        rdy = 1'b1;
      end else begin
        if (hold == 0) begin
          rdy = !rdy;
          if (rdy) hold = $urandom_range(1, 40);
          else hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
        end
        hold--;
      end
      out_bus.ready <= rdy;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // One input transaction; returns right after the accepting edge
  task automatic push_pixel(input logic md, input pix_t px);
    int gap;
    if (!no_idle && burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 32);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode  <= md;
    in_bus.red   <= px[7:0];
    in_bus.green <= px[15:8];
    in_bus.blue  <= px[23:16];
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    predict_sharpened(md, px);
    items_sent++;
    burst_left--;
  endtask

  // Sender idles until every owed pixel is out, then lets the pipeline empty
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    filter_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h, input int g);
    wait_idle();
    write_reg(CfgWidth, CfgDataW'(w));
    write_reg(CfgHeight, CfgDataW'(h));
    write_reg(CfgGain, g[GainW-1:0]);
  endtask

  function automatic pix_t pattern_px(pat_e pat, int x, int y, pix_t flat);
    pix_t px;
    case (pat)
      PatFlat:    px = flat;
      PatChecker: px = ((x + y) % 2 == 1) ? '1 : '0;
      PatSpeckle: begin
        for (int ch = 0; ch < 3; ch++)
          px[ChanW*ch +: ChanW] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PatRamp: begin
        for (int ch = 0; ch < 3; ch++)
          px[ChanW*ch +: ChanW] = chan_t'(x * 37 + y * 11 + ch * 50);
      end
      default:    px = pix_t'($urandom);
    endcase
    return px;
  endfunction

  // A whole frame plus w+1 drains. noise: percent of in-frame drain items.
  // pause_at >= 0: stop there, wait for idle and load a new gain mid-frame.
  task automatic send_frame(input int w, input int h, input pat_e pat, input int noise,
                            input int pause_at);
    pix_t flat;
    pix_t px;
    logic md;
    int   g;
    flat = pix_t'($urandom);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (y * w + x == pause_at) begin
          wait_idle();
          g = $urandom_range(0, 8191) - 4096;
          write_reg(CfgGain, g[GainW-1:0]);
        end
        px = pattern_px(pat, x, y, flat);
        md = (noise > 0 && $urandom_range(0, 99) < noise);
        if (md) px = pix_t'($urandom);   // payload must not matter
        push_pixel(md, px);
      end
    end
    for (int i = 0; i <= w; i++) push_pixel(1'b1, pix_t'($urandom));
    frames_sent++;
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reset values: full-width single row with zero gain, output equals input
  task automatic test_reset_defaults();
    send_frame(MaxWidth, 1, PatRandom, 0, -1);
  endtask

  // Tiny frames: out-of-range sizes, gain extremes, drains inside the frame,
  // one-pixel-wide column
  task automatic test_directed_edges();
    set_frame(0, 0, 4095);                     // zero width/height taken as 1
    send_frame(1, 1, PatSpeckle, 0, -1);
    set_frame(3, 2, -4096);
    send_frame(3, 2, PatChecker, 0, -1);
    set_frame(2, 2, 256);
    send_frame(2, 2, PatRandom, 50, -1);
    set_frame(1, 3, 4095);
    send_frame(1, 3, PatSpeckle, 0, -1);
  endtask

  // Registers changed mid-frame: stop at row 1 column 7 of an 8-wide frame, drop
  // width to 5 (column wraps late), grow height, new gain. Runs until last_pixel.
  task automatic test_mid_frame_update();
    set_frame(8, 3, 64);
    for (int i = 0; i < 15; i++) push_pixel(1'b0, pix_t'($urandom));
    wait_idle();
    write_reg(CfgGain, CfgDataW'(-300));
    write_reg(CfgWidth, CfgDataW'(5));
    write_reg(CfgHeight, CfgDataW'(4));
    frame_closed = 1'b0;
    while (!frame_closed) push_pixel(1'b0, pix_t'($urandom));
    frames_sent++;
  endtask

  // Largest sizes: width above the line store (taken as max) and height above max
  task automatic test_large_frames();
    set_frame(4095, 2, $urandom_range(0, 1000) - 500);
    send_frame(MaxWidth, 2, PatRamp, 0, -1);
    no_idle = 1'b1;
    set_frame(1, 8191, $urandom_range(0, 8191) - 4096);
    send_frame(1, MaxHeight, PatRandom, 5, -1);
    no_idle = 1'b0;
  endtask

  // Random frames, mostly small, some back to back with unchanged registers
  task automatic test_random_frames();
    int          w;
    int          h;
    int          g;
    int          sel;
    int          noise;
    int          pause_at;
    pat_e        pat;
    int unsigned start;
    start = items_sent;
    w     = 1;
    h     = 1;
    while (items_sent - start < RandItems) begin
      if (items_sent == start || $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 5);
        end else if (sel < 95) begin
          w = $urandom_range(9, 64);
          h = $urandom_range(1, 6);
        end else begin
          w = $urandom_range(65, 256);
          h = $urandom_range(1, 2);
        end
        case ($urandom_range(0, 5))
          0:       g = -4096;
          1:       g = 4095;
          2:       g = 0;
          3:       g = $urandom_range(0, 8191) - 4096;
          default: g = $urandom_range(0, 1200) - 600;
        endcase
        set_frame(w, h, g);
      end
      no_idle  = ($urandom_range(0, 4) == 0);
      pat      = pat_e'($urandom_range(0, 4));
      noise    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
      pause_at = ($urandom_range(0, 5) == 0 && w * h > 1) ? $urandom_range(1, w * h - 1) : -1;
      send_frame(w, h, pat, noise, pause_at);
    end
    no_idle = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin : main_seq
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgWidth;
    cfg_wdata_i   <= '0;
    in_bus.valid  <= 1'b0;
    in_bus.mode   <= 1'b0;
    in_bus.red    <= '0;
    in_bus.green  <= '0;
    in_bus.blue   <= '0;
    frame_closed  = 1'b0;
    filter_reset();
    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_edges();
    test_mid_frame_update();
    test_large_frames();
    test_random_frames();

    wait_idle();
    if (sharpened_q.size() != 0) begin
      fail_cnt += sharpened_q.size();
      $display("%0d expected pixels never arrived", sharpened_q.size());
    end
    $display("Covered %0d frames, %0d input transactions, %0d sharpened pixels checked",
             frames_sent, items_sent, results_seen);
    $display("Sizes 1x1 up to %0d wide / %0d high, gain extremes, mid-frame updates, %0d errors",
             MaxWidth, MaxHeight, fail_cnt);
    if (fail_cnt == 0) begin
      $display("** rgb_sharpen_3x3: PASSED **");
    end else begin
      $display("** rgb_sharpen_3x3: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("Timeout: %0d pixels still owed", sharpened_q.size());
    $display("** rgb_sharpen_3x3: FAILED **");
    $finish;
  end

endmodule
